// ===== sv/stereo_beat_oscillator_assert.svh =====
// assertion macros for the stereo beat oscillator checker
`ifndef STEREO_BEAT_OSCILLATOR_ASSERT_SVH
`define STEREO_BEAT_OSCILLATOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SBO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SBO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sbo_pkg.sv =====
// shared types, constants and table functions of the stereo beat oscillator
package sbo_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int EXP_TABLE_BITS_DEF  = 10;
    localparam int MAX_HARMONICS_DEF   = 16;

    localparam logic [24:0] C4_Q16      = 25'd17145893;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        CFG_BASE_PITCH = 3'd0,
        CFG_BEAT_FREQ  = 3'd1,
        CFG_WAVEFORM   = 3'd2,
        CFG_HARM_COUNT = 3'd3,
        CFG_HARM_STR   = 3'd4,
        CFG_HZ_TO_STEP = 3'd5,
        CFG_FM_EN      = 3'd6,
        CFG_SYNC_EN    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SAW    = 2'd3
    } t_wave;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_17 = 2'd2
    } t_sh;

    typedef struct packed {
        logic en;
        logic clr;
        t_sh  sh;
    } t_mac_op;

    // harmonic weights round(65536/n), indexed by n
    localparam logic [15:0] W_TAB [34] = '{
        16'd0,    16'd0,    16'd32768, 16'd21845, 16'd16384, 16'd13107, 16'd10923,
        16'd9362, 16'd8192, 16'd7282,  16'd6554,  16'd5958,  16'd5461,  16'd5041,
        16'd4681, 16'd4369, 16'd4096,  16'd3855,  16'd3641,  16'd3449,  16'd3277,
        16'd3121, 16'd2979, 16'd2849,  16'd2731,  16'd2621,  16'd2521,  16'd2427,
        16'd2341, 16'd2260, 16'd2185,  16'd2114,  16'd2048,  16'd1986
    };

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int it = 0; it < 32; it++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // q30 value of 2^(i/2^bits)
    function automatic logic [30:0] exp_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] roots [15];
        logic [63:0] e;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j < 15; j++) begin
            roots[j] = (j <= bits) ? isqrt64(roots[j-1] << 30) : 64'd0;
        end
        e = 64'd1 << 30;
        for (int j = 0; j < 14; j++) begin
            if (j < bits && ((i >> j) & 1) != 0) begin
                e = (e * roots[bits-j] + (64'd1 << 29)) >> 30;
            end
        end
        return e[30:0];
    endfunction

    // q15 quarter-wave sine entry, taylor series in q30
    function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] r;
        logic signed [63:0] sum;
        x = (64'(HALF_PI_Q30) * 64'(i)) >> bits;
        term = x;
        sum = signed'(x);
        for (int k = 1; k <= 8; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = (unsigned'(sum) + 64'd16384) >> 15;
        return (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

    // floor(v/3) by reciprocal and one correction
    function automatic logic [15:0] div3(input logic [15:0] v);
        logic [31:0] p;
        logic [15:0] q;
        p = 32'(v) * 32'd21846;
        q = p[31:16];
        if (32'(q) * 32'd3 > 32'(v)) begin
            q = q - 16'd1;
        end
        return q;
    endfunction

endpackage

// ===== sv/sbo_in_if.sv =====
// input channel of the stereo beat oscillator
interface sbo_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] fm_in;
    logic signed [14:0] sync_in;

    modport source (output valid, output fm_in, output sync_in, input ready);
    modport sink (input valid, input fm_in, input sync_in, output ready);
endinterface

// ===== sv/sbo_out_if.sv =====
// output channel of the stereo beat oscillator
interface sbo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== sv/sbo_mac.sv =====
// shared multiply-accumulate unit with partial-product shift
module sbo_mac (
    input  logic                 i_clk,
    input  sbo_pkg::t_mac_op     i_op,
    input  logic signed [25:0]   i_a,
    input  logic signed [20:0]   i_b,
    output logic signed [63:0]   o_acc
);
    logic signed [46:0] w_prod;
    logic signed [63:0] w_term;
    logic signed [63:0] r_acc;

    assign w_prod = i_a * i_b;

    always_comb begin
        unique case (i_op.sh)
            sbo_pkg::SH_16: w_term = 64'(w_prod) <<< 16;
            sbo_pkg::SH_17: w_term = 64'(w_prod) <<< 17;
            default:        w_term = 64'(w_prod);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= (i_op.clr ? 64'sd0 : r_acc) + w_term;
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== sv/sbo_div.sv =====
// restoring divider, one quotient bit per cycle
module sbo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [34:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);
    localparam int QB = 17;
    localparam int CB = $clog2(QB + 1);

    logic [17:0]   r_rem;
    logic [QB-1:0] r_low;
    logic [17:0]   r_den;
    logic [CB-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [18:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_low[QB-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CB'(1);
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient fits QB bits, so the high part is below the divisor
            r_rem <= i_num[34:QB];
            r_low <= i_num[QB-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 18'(w_trial - {1'b0, r_den}) : w_trial[17:0];
            r_low <= {r_low[QB-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;
endmodule

// ===== sv/sbo_shape.sv =====
// waveform shaper with quarter-wave sine table, registered output
module sbo_shape #(
    parameter int PHASE_BITS      = sbo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = sbo_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  logic [1:0]            i_wave,
    output logic signed [16:0]    o_val
);
    localparam int SB = SINE_TABLE_BITS;
    localparam int SN = 1 << SB;

    typedef logic [15:0] t_sine_tab [SN+1];

    function automatic t_sine_tab f_build();
        t_sine_tab t;
        for (int i = 0; i <= SN; i++) begin
            t[i] = sbo_pkg::sine_entry(i, SB);
        end
        return t;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build();

    logic [15:0]        w_t;
    logic [1:0]         w_q;
    logic [SB-1:0]      w_i;
    logic [SB:0]        w_idx;
    logic [15:0]        w_sin;
    logic signed [17:0] w_t2;
    logic signed [17:0] w_tri;
    logic signed [16:0] w_val;

    assign w_t   = i_phase[PHASE_BITS-1 -: 16];
    assign w_q   = i_phase[PHASE_BITS-1 -: 2];
    assign w_i   = i_phase[PHASE_BITS-3 -: SB];
    // odd quadrants run the table backward
    assign w_idx = w_q[0] ? ((SB+1)'(SN) - {1'b0, w_i}) : {1'b0, w_i};
    assign w_sin = SINE_TAB[w_idx];
    assign w_t2  = $signed({1'b0, w_t, 1'b0});
    assign w_tri = w_t[15] ? (18'sd98304 - w_t2) : (w_t2 - 18'sd32768);

    always_comb begin
        unique case (sbo_pkg::t_wave'(i_wave))
            sbo_pkg::WAVE_SQUARE: w_val = w_t[15] ? -17'sd32767 : 17'sd32767;
            sbo_pkg::WAVE_TRI:    w_val = 17'(w_tri);
            sbo_pkg::WAVE_SAW:    w_val = $signed({1'b0, w_t}) - 17'sd32768;
            default:              w_val = w_q[1] ? -$signed({1'b0, w_sin})
                                                 : $signed({1'b0, w_sin});
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_val <= w_val;
    end
endmodule

// ===== sv/stereo_beat_oscillator.sv =====
// top level of the stereo beat oscillator
//
// one item on i_in carries fm_in and sync_in for one audio sample; one item on
// o_out returns left_out and right_out for it. both are valid/ready channels.
// registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user is to
// write them only while idle, which the block itself does not enforce. i_in.ready
// is high only while the sequencer sits idle; the block works on one item at a
// time through a single shared multiply-accumulate unit, a shared restoring
// divider and one waveform shaper. per item, a front end turns the pitch into a
// carrier; per channel, the step and phase advance follow, then the harmonic loop
// (one harmonic per cycle through the shaper) and, only with harmonics active
// (count and strength non-zero), the divide and the weighted mix; a hand-off
// state ends the item. the result sits in an output register; a new item is taken
// while it waits, and the sequencer holds before writing the next result until it
// is taken. reset (synchronous, active low) clears both phases, the last sync
// sample, the registers to their reset values and the output valid.
module stereo_beat_oscillator #(
    parameter int PHASE_BITS      = sbo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = sbo_pkg::SINE_TABLE_BITS_DEF,
    parameter int EXP_TABLE_BITS  = sbo_pkg::EXP_TABLE_BITS_DEF,
    parameter int MAX_HARMONICS   = sbo_pkg::MAX_HARMONICS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbo_in_if.sink                         i_in,
    sbo_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sbo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int PB = PHASE_BITS;
    localparam int EB = EXP_TABLE_BITS;
    localparam int EN = 1 << EB;
    localparam int CW = $clog2(MAX_HARMONICS + 1);

    typedef logic [30:0] t_exp_tab [EN];

    function automatic t_exp_tab f_build();
        t_exp_tab t;
        for (int i = 0; i < EN; i++) begin
            t[i] = sbo_pkg::exp_entry(i, EB);
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = f_build();

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_OCT   = 20'h00002,
        S_IDX   = 20'h00004,
        S_EXP   = 20'h00008,
        S_C0    = 20'h00010,
        S_C1    = 20'h00020,
        S_CAR   = 20'h00040,
        S_FREQ  = 20'h00080,
        S_P0    = 20'h00100,
        S_P1    = 20'h00200,
        S_ADV   = 20'h00400,
        S_BASE  = 20'h00800,
        S_HARM  = 20'h01000,
        S_DIV   = 20'h02000,
        S_DWAIT = 20'h04000,
        S_M0    = 20'h08000,
        S_M1    = 20'h10000,
        S_MIX   = 20'h20000,
        S_DONE  = 20'h40000,
        S_SPARE = 20'h80000
    } t_state;

    // configuration registers
    logic signed [14:0] r_base;
    logic [13:0]        r_beat;
    logic [1:0]         r_wave;
    logic [4:0]         r_hcnt;
    logic [16:0]        r_hstr;
    logic [19:0]        r_h2s;
    logic               r_fm_en;
    logic               r_sync_en;

    // oscillator state
    logic [PB-1:0]      r_ph_l;
    logic [PB-1:0]      r_ph_r;
    logic signed [14:0] r_last;

    // sequencer and datapath
    t_state             r_state;
    t_state             n_state;
    logic               r_ch;
    logic [15:0]        r_u;
    logic [4:0]         r_oct;
    logic [11:0]        r_frac;
    logic [EB-1:0]      r_idx;
    logic [30:0]        r_exp;
    logic [33:0]        r_car;
    logic [33:0]        r_mag;
    logic               r_neg;
    logic [PB-1:0]      r_p;
    logic [PB-1:0]      r_hp;
    logic [CW-1:0]      r_k;
    logic signed [16:0] r_sig;
    logic [17:0]        r_wsum;
    logic               r_hneg;
    logic signed [17:0] r_hs;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    logic               r_o_valid;
    logic signed [15:0] r_o_left;
    logic signed [15:0] r_o_right;

    logic               w_in_acc;
    logic signed [17:0] w_fm3;
    logic signed [17:0] w_pitch;
    logic signed [17:0] w_pclamp;
    logic               w_edge;
    logic [4:0]         w_oct;
    logic [11+EB:0]     w_fe;
    logic [26:0]        w_cbase;
    logic [33:0]        w_car;
    logic [20:0]        w_half;
    logic signed [34:0] w_f;
    logic [PB-1:0]      w_st;
    logic [PB-1:0]      w_ph;
    logic [PB-1:0]      w_ph_new;
    logic [CW-1:0]      w_cnt;
    logic [16:0]        w_s;
    logic               w_active;
    logic [5:0]         w_n;
    logic [15:0]        w_w;
    logic signed [63:0] w_trunc;
    logic signed [15:0] w_res;
    logic [PB-1:0]      w_shp_ph;
    logic signed [16:0] w_shp;
    sbo_pkg::t_mac_op   w_op;
    logic signed [25:0] w_a;
    logic signed [20:0] w_b;
    logic signed [63:0] w_acc;
    logic               w_div_start;
    logic [34:0]        w_div_num;
    logic               w_div_done;
    logic [16:0]        w_quot;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_o_valid;
    assign o_out.left_out  = r_o_left;
    assign o_out.right_out = r_o_right;

    // pitch: base plus 3 units per fm unit, saturated to +-96 semitones
    assign w_fm3   = $signed({{3{i_in.fm_in[14]}}, i_in.fm_in})
                   + $signed({{2{i_in.fm_in[14]}}, i_in.fm_in, 1'b0});
    assign w_pitch = $signed({{3{r_base[14]}}, r_base}) + (r_fm_en ? w_fm3 : 18'sd0);

    always_comb begin
        priority if (w_pitch > 18'sd24576) begin
            w_pclamp = 18'sd24576;
        end else if (w_pitch < -18'sd24576) begin
            w_pclamp = -18'sd24576;
        end else begin
            w_pclamp = w_pitch;
        end
    end

    // rising sync edge above 1 V
    assign w_edge = r_sync_en && (i_in.sync_in > 15'sd1024) && (r_last <= 15'sd1024);

    // octave and position within it
    assign w_oct   = 5'(sbo_pkg::div3({10'd0, r_u[15:10]}));
    assign w_fe    = {r_frac, {EB{1'b0}}};

    // carrier: c4 times table value, shifted by the octave offset
    assign w_cbase = w_acc[56:30];
    assign w_car   = (r_oct >= 5'd8) ? (34'(w_cbase) << (r_oct - 5'd8))
                                     : (34'(w_cbase) >> (5'd8 - r_oct));

    // channel frequency, left above and right below the carrier
    assign w_half = {r_beat, 7'd0};
    assign w_f    = r_ch ? ($signed({1'b0, r_car}) - $signed({14'd0, w_half}))
                         : ($signed({1'b0, r_car}) + $signed({14'd0, w_half}));

    // phase step and advance
    assign w_st     = w_acc[48-PB +: PB];
    assign w_ph     = r_ch ? r_ph_r : r_ph_l;
    assign w_ph_new = r_neg ? (w_ph - w_st) : (w_ph + w_st);

    // harmonic control
    assign w_cnt    = ({1'b0, r_hcnt} > 6'(MAX_HARMONICS)) ? CW'(MAX_HARMONICS)
                                                          : CW'(r_hcnt);
    assign w_s      = (r_hstr > 17'd65536) ? 17'd65536 : r_hstr;
    assign w_active = (w_cnt != '0) && (w_s != 17'd0);
    assign w_n      = 6'(r_k) + 6'd1;
    assign w_w      = sbo_pkg::W_TAB[w_n];

    // mix result, truncated toward zero and clamped
    assign w_trunc = (w_acc + (w_acc[63] ? 64'sd65535 : 64'sd0)) >>> 16;

    always_comb begin
        logic signed [63:0] v;
        v = w_active ? w_trunc : 64'(r_sig);
        priority if (v > 64'sd32767) begin
            w_res = 16'sd32767;
        end else if (v < -64'sd32767) begin
            w_res = -16'sd32767;
        end else begin
            w_res = 16'(v);
        end
    end

    assign w_shp_ph    = (r_state == S_BASE) ? r_p : r_hp;
    assign w_div_start = (r_state == S_DIV);
    assign w_div_num   = w_acc[63] ? 35'(-w_acc) : 35'(w_acc);

    // operand selection for the shared mac
    always_comb begin
        w_op = '{en: 1'b0, clr: 1'b0, sh: sbo_pkg::SH_0};
        w_a  = 26'sd0;
        w_b  = 21'sd0;
        unique case (r_state)
            S_C0: begin
                w_op = '{en: 1'b1, clr: 1'b1, sh: sbo_pkg::SH_0};
                w_a  = $signed({1'b0, sbo_pkg::C4_Q16});
                w_b  = $signed({5'd0, r_exp[15:0]});
            end
            S_C1: begin
                w_op = '{en: 1'b1, clr: 1'b0, sh: sbo_pkg::SH_16};
                w_a  = $signed({1'b0, sbo_pkg::C4_Q16});
                w_b  = $signed({6'd0, r_exp[30:16]});
            end
            S_P0: begin
                w_op = '{en: 1'b1, clr: 1'b1, sh: sbo_pkg::SH_0};
                w_a  = $signed({9'd0, r_mag[16:0]});
                w_b  = $signed({1'b0, r_h2s});
            end
            S_P1: begin
                w_op = '{en: 1'b1, clr: 1'b0, sh: sbo_pkg::SH_17};
                w_a  = $signed({9'd0, r_mag[33:17]});
                w_b  = $signed({1'b0, r_h2s});
            end
            S_HARM: begin
                // first pass clears, later passes add shape times weight
                w_op = '{en: 1'b1, clr: (r_k == '0), sh: sbo_pkg::SH_0};
                w_a  = (r_k == '0) ? 26'sd0 : 26'(w_shp);
                w_b  = $signed({5'd0, w_w});
            end
            S_M0: begin
                w_op = '{en: 1'b1, clr: 1'b1, sh: sbo_pkg::SH_0};
                w_a  = 26'(r_sig);
                w_b  = $signed({4'd0, 17'(18'd65536 - {1'b0, w_s})});
            end
            S_M1: begin
                w_op = '{en: 1'b1, clr: 1'b0, sh: sbo_pkg::SH_0};
                w_a  = 26'(r_hs);
                w_b  = $signed({4'd0, w_s});
            end
            default: begin
                w_op = '{en: 1'b0, clr: 1'b0, sh: sbo_pkg::SH_0};
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_OCT;
            S_OCT:   n_state = S_IDX;
            S_IDX:   n_state = S_EXP;
            S_EXP:   n_state = S_C0;
            S_C0:    n_state = S_C1;
            S_C1:    n_state = S_CAR;
            S_CAR:   n_state = S_FREQ;
            S_FREQ:  n_state = S_P0;
            S_P0:    n_state = S_P1;
            S_P1:    n_state = S_ADV;
            S_ADV:   n_state = S_BASE;
            S_BASE:  n_state = S_HARM;
            S_HARM: begin
                if (r_k == w_cnt) begin
                    n_state = w_active ? S_DIV : S_MIX;
                end
            end
            S_DIV:   n_state = S_DWAIT;
            S_DWAIT: if (w_div_done) n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_MIX;
            S_MIX:   n_state = r_ch ? S_DONE : S_FREQ;
            S_DONE:  if (!r_o_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state, configuration and oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ch      <= 1'b0;
            r_o_valid <= 1'b0;
            r_base    <= 15'sd0;
            r_beat    <= 14'd2560;
            r_wave    <= 2'd0;
            r_hcnt    <= 5'd0;
            r_hstr    <= 17'd0;
            r_h2s     <= 20'd97392;
            r_fm_en   <= 1'b0;
            r_sync_en <= 1'b0;
            r_ph_l    <= '0;
            r_ph_r    <= '0;
            r_last    <= 15'sd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (sbo_pkg::t_cfg_idx'(i_cfg_idx))
                    sbo_pkg::CFG_BASE_PITCH: r_base    <= $signed(i_cfg_data[14:0]);
                    sbo_pkg::CFG_BEAT_FREQ:  r_beat    <= i_cfg_data[13:0];
                    sbo_pkg::CFG_WAVEFORM:   r_wave    <= i_cfg_data[1:0];
                    sbo_pkg::CFG_HARM_COUNT: r_hcnt    <= i_cfg_data[4:0];
                    sbo_pkg::CFG_HARM_STR:   r_hstr    <= i_cfg_data[16:0];
                    sbo_pkg::CFG_HZ_TO_STEP: r_h2s     <= i_cfg_data[19:0];
                    sbo_pkg::CFG_FM_EN:      r_fm_en   <= i_cfg_data[0];
                    sbo_pkg::CFG_SYNC_EN:    r_sync_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_ch <= 1'b0;
                if (r_sync_en) begin
                    r_last <= i_in.sync_in;
                end
                // sync edge clears both phases before they advance
                if (w_edge) begin
                    r_ph_l <= '0;
                    r_ph_r <= '0;
                end
            end
            if (r_state == S_ADV) begin
                if (r_ch) begin
                    r_ph_r <= w_ph_new;
                end else begin
                    r_ph_l <= w_ph_new;
                end
            end
            if (r_state == S_MIX) begin
                r_ch <= 1'b1;
            end
            if (o_out.valid && o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_DONE && (!r_o_valid || o_out.ready)) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_u <= 16'(w_pclamp + 18'sd24576);
        end
        if (r_state == S_OCT) begin
            r_oct  <= w_oct;
            r_frac <= 12'(r_u - {w_oct, 11'd0} - {1'b0, w_oct, 10'd0});
        end
        if (r_state == S_IDX) begin
            r_idx <= EB'(sbo_pkg::div3(16'(w_fe >> 10)));
        end
        if (r_state == S_EXP) begin
            r_exp <= EXP_TAB[r_idx];
        end
        if (r_state == S_CAR) begin
            r_car <= w_car;
        end
        if (r_state == S_FREQ) begin
            r_neg <= w_f[34];
            r_mag <= w_f[34] ? 34'(-w_f) : 34'(w_f);
        end
        if (r_state == S_ADV) begin
            r_p <= w_ph_new;
        end
        if (r_state == S_BASE) begin
            r_hp <= {r_p[PB-2:0], 1'b0};
            r_k  <= '0;
        end
        if (r_state == S_HARM) begin
            r_hp <= r_hp + r_p;
            r_k  <= r_k + CW'(1);
            if (r_k == '0) begin
                r_sig  <= w_shp;
                r_wsum <= 18'd0;
            end else begin
                r_wsum <= r_wsum + {2'd0, w_w};
            end
        end
        if (r_state == S_DIV) begin
            r_hneg <= w_acc[63];
        end
        if (r_state == S_DWAIT && w_div_done) begin
            r_hs <= r_hneg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        end
        if (r_state == S_MIX) begin
            if (r_ch) begin
                r_right <= w_res;
            end else begin
                r_left <= w_res;
            end
        end
        if (r_state == S_DONE && (!r_o_valid || o_out.ready)) begin
            r_o_left  <= r_left;
            r_o_right <= r_right;
        end
    end

    sbo_shape #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_shape (
        .i_clk   (i_clk),
        .i_phase (w_shp_ph),
        .i_wave  (r_wave),
        .o_val   (w_shp)
    );

    sbo_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc)
    );

    sbo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_wsum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );
endmodule

// ===== sv/sbo_checker.sv =====
// port-level checker for the stereo beat oscillator, with its bind
`include "stereo_beat_oscillator_assert.svh"

module sbo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_left,
    input logic signed [15:0] i_right
);
    // an accepted item keeps the block busy on the next cycle
    `SBO_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")

    // a new result appears only after the block has been busy
    `SBO_ASSERT_NOW(a_result_from_work, $rose(i_out_valid), $past(!i_in_ready), "result while idle")

    // results are clamped to the symmetric range
    `SBO_ASSERT_NOW(a_clamped, i_out_valid, i_left != -16'sd32768 && i_right != -16'sd32768, "result out of range")

    // a waiting result is not dropped
    `SBO_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
endmodule

bind stereo_beat_oscillator sbo_checker u_sbo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left      (o_out.left_out),
    .i_right     (o_out.right_out)
);

// ===== dv/tb_stereo_beat_oscillator.sv =====
// self-checking testbench for the stereo beat oscillator top level
module tb_stereo_beat_oscillator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake before giving up
    localparam int DRAIN_WAIT  = 150;    // wait after the last sample, longer than the worst item plus hand-off
    localparam int LONG_HOLD   = 500;    // receiver hold-off, long enough to fill the block

    typedef struct {
        logic signed [14:0] fm;
        logic signed [14:0] sync;
    } t_cv_item;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_stereo_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sbo_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sbo_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    sbo_in_if  cv_ch ();
    sbo_out_if audio_ch ();

    stereo_beat_oscillator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cv_ch.sink),
        .o_out      (audio_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // lookup tables of the predictor, built once at time zero
    bit [15:0] sine_q15 [0:1024];
    bit [31:0] exp2_q30 [0:1023];

    // register shadow
    int              pitch_ofs;
    int unsigned     beat_q8;
    sbo_pkg::t_wave  wave_sel;
    int unsigned     harm_cnt;
    int unsigned     harm_mix;
    int unsigned     step_per_hz;
    bit              fm_on;
    bit              sync_on;

    // oscillator state shadow
    bit [31:0]          acc_left;
    bit [31:0]          acc_right;
    logic signed [14:0] prev_sync;

    t_cv_item       cv_pending [$];
    t_stereo_sample samples_due [$];
    int             mismatches = 0;
    bit             no_idle = 1'b0;      // back-to-back stretch on both sides
    bit             hold_request = 1'b0; // asks the receiver for one long hold-off
    bit             sync_high = 1'b0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic build_lookup();
        longint unsigned roots [0:10];
        longint unsigned e;
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint unsigned r;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= 10; j++) roots[j] = int_sqrt(roots[j-1] << 30);
        for (int i = 0; i < 1024; i++) begin
            e = 64'd1 << 30;
            for (int j = 0; j < 10; j++)
                if ((i >> j) & 1) e = (e * roots[10-j] + (64'd1 << 29)) >> 30;
            exp2_q30[i] = e[31:0];
        end
        // quarter-wave sine by taylor series in q30
        for (int i = 0; i <= 1024; i++) begin
            x = (64'(sbo_pkg::HALF_PI_Q30) * 64'(i)) / 1024;
            term = x;
            acc = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k & 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            r = (longint'(acc) + 16384) >> 15;
            sine_q15[i] = (r > 32767) ? 16'd32767 : r[15:0];
        end
    endtask

    task automatic clear_shadow();
        pitch_ofs = 0;
        beat_q8 = 2560;
        wave_sel = sbo_pkg::WAVE_SINE;
        harm_cnt = 0;
        harm_mix = 0;
        step_per_hz = 97392;
        fm_on = 1'b0;
        sync_on = 1'b0;
        acc_left = '0;
        acc_right = '0;
        prev_sync = '0;
    endtask

    function automatic int wave_point(input bit [31:0] p);
        int t;
        bit [9:0] ti;
        int mag;
        t = int'(p[31:16]);
        case (wave_sel)
            sbo_pkg::WAVE_SQUARE: return (t < 32768) ? 32767 : -32767;
            sbo_pkg::WAVE_TRI:    return (t < 32768) ? 2 * t - 32768 : 98304 - 2 * t;
            sbo_pkg::WAVE_SAW:    return t - 32768;
            default: begin
                // mirror the table on odd quadrants, negate on the second half
                ti = p[29:20];
                mag = p[30] ? int'(sine_q15[1024 - int'(ti)]) : int'(sine_q15[ti]);
                return p[31] ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic signed [15:0] render_voice(input bit [31:0] p);
        longint sig;
        longint mix;
        longint hacc;
        longint wsum;
        longint w;
        int unsigned cnt;
        bit [63:0] hp;
        sig = wave_point(p);
        cnt = (harm_cnt > 16) ? 16 : harm_cnt;
        mix = (harm_mix > 65536) ? 65536 : harm_mix;
        if (cnt > 0 && mix > 0) begin
            hacc = 0;
            wsum = 0;
            for (int n = 2; n <= cnt + 1; n++) begin
                w = (65536 + n / 2) / n;
                hp = 64'(p) * 64'(n);
                hacc += longint'(wave_point(hp[31:0])) * w;
                wsum += w;
            end
            sig = (sig * (65536 - mix) + (hacc / wsum) * mix) / 65536;
        end
        if (sig > 32767) sig = 32767;
        if (sig < -32767) sig = -32767;
        return sig[15:0];
    endfunction

    function automatic bit [31:0] step_phase(input bit [31:0] ph, input longint f);
        longint unsigned mag;
        longint unsigned st;
        mag = (f < 0) ? longint'(-f) : longint'(f);
        st = (mag * 64'(step_per_hz)) >> 16;
        return (f < 0) ? ph - st[31:0] : ph + st[31:0];
    endfunction

    // one audio sample: pitch to carrier, sync, advance both phases, shape
    function automatic t_stereo_sample oscillate(input t_cv_item cv);
        longint pitch;
        longint carrier;
        longint half_beat;
        int unsigned u;
        int unsigned oct;
        int unsigned idx;
        t_stereo_sample s;
        pitch = pitch_ofs;
        if (fm_on) pitch += 3 * longint'(cv.fm);
        if (pitch > 24576) pitch = 24576;
        if (pitch < -24576) pitch = -24576;
        u = int'(pitch + 24576);
        oct = u / 3072;
        idx = ((u % 3072) << 10) / 3072;
        carrier = (longint'(sbo_pkg::C4_Q16) * longint'(exp2_q30[idx])) >>> 30;
        if (oct >= 8) carrier = carrier <<< (oct - 8);
        else carrier = carrier >>> (8 - oct);
        half_beat = longint'(beat_q8) * 128;
        if (sync_on) begin
            // rising edge through 1 V restarts both channels
            if (cv.sync > 1024 && prev_sync <= 1024) begin
                acc_left = '0;
                acc_right = '0;
            end
            prev_sync = cv.sync;
        end
        acc_left = step_phase(acc_left, carrier + half_beat);
        acc_right = step_phase(acc_right, carrier - half_beat);
        s.left = render_voice(acc_left);
        s.right = render_voice(acc_right);
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // sender: one offer per item, a random gap after each accepted item
    int cv_gap = 0;
    always @(posedge i_clk) begin
        t_cv_item nxt;
        t_cv_item sent;
        if (!i_rst_n) begin
            cv_ch.valid <= 1'b0;
            cv_ch.fm_in <= '0;
            cv_ch.sync_in <= '0;
            cv_gap = 0;
        end else if (!(cv_ch.valid && !cv_ch.ready)) begin
            if (cv_ch.valid) begin
                sent.fm = cv_ch.fm_in;
                sent.sync = cv_ch.sync_in;
                samples_due.push_back(oscillate(sent));
                cv_gap = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (cv_gap == 0 && cv_pending.size() > 0) begin
                nxt = cv_pending.pop_front();
                cv_ch.valid <= 1'b1;
                cv_ch.fm_in <= nxt.fm;
                cv_ch.sync_in <= nxt.sync;
            end else begin
                cv_ch.valid <= 1'b0;
                if (cv_gap > 0) cv_gap--;
            end
        end
    end

    // receiver: random stall after each sample, one long hold-off on request
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_stereo_sample want;
        if (!i_rst_n) begin
            audio_ch.ready <= 1'b0;
        end else begin
            if (audio_ch.valid && audio_ch.ready) begin
                if (samples_due.size() == 0) begin
                    report_mismatch("unexpected sample, left", audio_ch.left_out, 0);
                end else begin
                    want = samples_due.pop_front();
                    if (audio_ch.left_out !== want.left)
                        report_mismatch("left_out", audio_ch.left_out, want.left);
                    if (audio_ch.right_out !== want.right)
                        report_mismatch("right_out", audio_ch.right_out, want.right);
                end
                rx_gap = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                audio_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                audio_ch.ready <= 1'b0;
            end else begin
                audio_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((cv_ch.valid && cv_ch.ready) || (audio_ch.valid && audio_ch.ready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("stereo_beat_oscillator test failed");
            $finish;
        end
    end

    task automatic write_reg(input sbo_pkg::t_cfg_idx idx,
                             input bit [sbo_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            sbo_pkg::CFG_BASE_PITCH: pitch_ofs = int'(signed'(val[14:0]));
            sbo_pkg::CFG_BEAT_FREQ:  beat_q8 = val[13:0];
            sbo_pkg::CFG_WAVEFORM:   wave_sel = sbo_pkg::t_wave'(val[1:0]);
            sbo_pkg::CFG_HARM_COUNT: harm_cnt = val[4:0];
            sbo_pkg::CFG_HARM_STR:   harm_mix = val[16:0];
            sbo_pkg::CFG_HZ_TO_STEP: step_per_hz = val;
            sbo_pkg::CFG_FM_EN:      fm_on = val[0];
            default:                 sync_on = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // low, high and random settings; sel picks which extreme
    task automatic program_regs(input int sel);
        int v;
        case (sel)
            1: v = 16383;
            2: v = -16384;
            default: v = ($urandom_range(0, 3) == 0) ? 13824 * ($urandom_range(0, 1) ? 1 : -1)
                                                     : $urandom_range(0, 27648) - 13824;
        endcase
        write_reg(sbo_pkg::CFG_BASE_PITCH, 20'(v));
        write_reg(sbo_pkg::CFG_BEAT_FREQ, sel == 1 ? 20'd16383 : sel == 2 ? 20'd0
                                          : 20'($urandom_range(0, 10240)));
        write_reg(sbo_pkg::CFG_WAVEFORM, 20'($urandom_range(0, 3)));
        write_reg(sbo_pkg::CFG_HARM_COUNT, sel == 1 ? 20'd31 : sel == 2 ? 20'd1
                                           : 20'($urandom_range(0, 16)));
        case (sel)
            1: v = 131071;
            2: v = 1;
            default: v = ($urandom_range(0, 2) == 0) ? 65536 : $urandom_range(0, 65536);
        endcase
        write_reg(sbo_pkg::CFG_HARM_STR, 20'(v));
        write_reg(sbo_pkg::CFG_HZ_TO_STEP, sel == 1 ? 20'hFFFFF : sel == 2 ? 20'd22369
                                           : 20'($urandom_range(22369, 536871)));
        write_reg(sbo_pkg::CFG_FM_EN, 20'($urandom_range(0, 3) != 0));
        write_reg(sbo_pkg::CFG_SYNC_EN, 20'($urandom_range(0, 3) != 0));
    endtask

    // sync mostly as pulse trains crossing the 1 V threshold, some noise
    function automatic t_cv_item random_cv();
        t_cv_item c;
        c.fm = ($urandom_range(0, 7) == 0) ? 15'($urandom)
                                           : 15'($urandom_range(0, 20480) - 10240);
        if ($urandom_range(0, 4) == 0) begin
            c.sync = 15'($urandom);
        end else begin
            if ($urandom_range(0, 3) == 0) sync_high = !sync_high;
            c.sync = sync_high ? 15'($urandom_range(1025, 10240))
                               : 15'($urandom_range(0, 11264) - 10240);
        end
        return c;
    endfunction

    task automatic queue_cv(input int fm, input int sync);
        t_cv_item c;
        c.fm = 15'(fm);
        c.sync = 15'(sync);
        cv_pending.push_back(c);
    endtask

    // sender pauses until every sample is back, then the block is idle
    task automatic drain();
        while (!(cv_pending.size() == 0 && !cv_ch.valid && samples_due.size() == 0))
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        build_lookup();
        clear_shadow();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, fm ignored, then fm and sync on with
        // pitch saturation, sync edges at the threshold and backward phase
        queue_cv(10240, 0);
        queue_cv(-10240, 2000);
        drain();
        write_reg(sbo_pkg::CFG_FM_EN, 20'd1);
        write_reg(sbo_pkg::CFG_SYNC_EN, 20'd1);
        write_reg(sbo_pkg::CFG_BASE_PITCH, 20'(13824));
        write_reg(sbo_pkg::CFG_BEAT_FREQ, 20'd10240);
        for (int w = 0; w < 4; w++) begin
            write_reg(sbo_pkg::CFG_WAVEFORM, 20'(w));
            queue_cv(10240, 1024);   // no edge exactly at 1 V
            queue_cv(16383, 1025);   // edge just above, pitch pinned high
            queue_cv(-16384, 10240); // still high, no new edge, pitch pinned low
            queue_cv(0, -10240);
            queue_cv(-9000, 1025);   // fresh edge while running backward
            drain();
        end

        // random phases, extremes in some, one back-to-back and one long hold
        for (int ph = 0; ph < 8; ph++) begin
            program_regs(ph == 1 ? 1 : ph == 2 ? 2 : 0);
            no_idle = (ph == 3);
            if (ph == 4) hold_request = 1'b1;
            for (int k = 0; k < 110; k++) cv_pending.push_back(random_cv());
            drain();
        end

        if (mismatches == 0) begin
            $display("stereo_beat_oscillator test passed");
        end else begin
            $display("stereo_beat_oscillator test failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/sbo_pkg.sv
sv/sbo_in_if.sv
sv/sbo_out_if.sv
sv/sbo_mac.sv
sv/sbo_div.sv
sv/sbo_shape.sv
sv/stereo_beat_oscillator.sv
sv/sbo_checker.sv
dv/tb_stereo_beat_oscillator.sv
